// File: hw/rtl/lcfs_pkg.sv
// ----------------------------------------------------------------------------
// lcfs_pkg
// Shared types and constants for the LED colour fade shader.
// ----------------------------------------------------------------------------
`default_nettype none

package lcfs_pkg;

  typedef enum logic [1:0] {
    MODE_STATIC = 2'd0,
    MODE_FADE   = 2'd1,
    MODE_BIFADE = 2'd2,
    MODE_MONO   = 2'd3
  } shade_mode_t;

  localparam int unsigned ColW  = 8;
  localparam int unsigned StepW = 11;
  localparam int unsigned PosW  = 9;

  localparam logic [StepW-1:0] FADE_PERIOD  = 11'd1530;
  localparam logic [StepW-1:0] MONO_PERIOD  = 11'd510;
  localparam logic [StepW-1:0] STATIC_PER   = 11'd0;
  localparam logic [StepW-1:0] THIRD_LEN    = 11'd510;
  localparam logic [StepW-1:0] THIRD_LEN_X2 = 11'd1020;
  localparam logic [StepW-1:0] MONO_X2      = 11'd1020;
  localparam logic [StepW-1:0] MONO_X3      = 11'd1530;
  localparam logic [StepW-1:0] MONO_X4      = 11'd2040;
  localparam logic [PosW-1:0]  HALF_RAMP    = 9'd255;
  localparam logic [PosW-1:0]  RAMP_LEN     = 9'd510;

endpackage

`default_nettype wire

// File: hw/rtl/lcfs_ramp.sv
// ----------------------------------------------------------------------------
// lcfs_ramp
// Scales one base level by a triangle level: base * lvl / 255, truncated.
// ----------------------------------------------------------------------------
`default_nettype none

module lcfs_ramp
  import lcfs_pkg::*;
(
  input  wire logic [ColW-1:0] base,
  input  wire logic [ColW-1:0] lvl,
  output logic      [ColW-1:0] level
);

  logic [2*ColW-1:0] prod;
  logic [2*ColW-1:0] adj;

  // floor(x / 255) = (x + (x >> 8) + 1) >> 8 over the product range
  assign prod  = base * lvl;
  assign adj   = prod + (prod >> ColW) + (2*ColW)'(1);
  assign level = adj[2*ColW-1:ColW];

endmodule

`default_nettype wire

// File: hw/rtl/led_color_fade_shader_core.sv
// ----------------------------------------------------------------------------
// led_color_fade_shader_core
// Per-pixel colour shader: static, fade, bifade and monofade animation.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   input   | start / busy         | in_red_in, in_green_in, in_blue_in, in_step
//   result  | out_valid (strobe)   | out_red_out, out_green_out, out_blue_out,
//           |                      | out_period
//   config  | cfg_valid/cfg_ready  | cfg_data (shade mode)
//
// One item per clock; busy is never raised. Each transfer passes through the
// input register, then step reduction, ramp multiply and /255 into the result
// register. The receiver cannot stall. Synchronous reset clears the valid
// flags and sets the mode to static.
// ----------------------------------------------------------------------------
`default_nettype none

module led_color_fade_shader_core
  import lcfs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [ColW-1:0]  in_red_in,
  input  wire logic [ColW-1:0]  in_green_in,
  input  wire logic [ColW-1:0]  in_blue_in,
  input  wire logic [StepW-1:0] in_step,
  output logic                  out_valid,
  output logic      [ColW-1:0]  out_red_out,
  output logic      [ColW-1:0]  out_green_out,
  output logic      [ColW-1:0]  out_blue_out,
  output logic      [StepW-1:0] out_period,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [1:0]       cfg_data
);

  shade_mode_t      mode_r;
  logic             in_vld_r;
  shade_mode_t      imode_r;
  logic [ColW-1:0]  base_r [3];
  logic [StepW-1:0] step_r;

  logic             res_vld_r;
  logic [ColW-1:0]  res_r [3];
  logic [StepW-1:0] per_r;

  logic [StepW-1:0] fade_s, fade_d1, fade_d2, mono_s;
  logic [2:0]       fade_m, mono_m, ramp_m;
  logic [PosW-1:0]  fade_pos, pos;
  logic [ColW-1:0]  tri_lvl;
  logic [PosW-1:0]  tri_down;
  logic [ColW-1:0]  ramped [3];
  logic [ColW-1:0]  res_nxt [3];
  logic [StepW-1:0] per_nxt;
  logic [ColW-1:0]  gb_max;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_STATIC;
      in_vld_r  <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_r <= shade_mode_t'(cfg_data);
      end
      in_vld_r  <= start && !busy;
      res_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      imode_r   <= mode_r;
      base_r[0] <= in_red_in;
      base_r[1] <= in_green_in;
      base_r[2] <= in_blue_in;
      step_r    <= in_step;
    end
    res_r[0] <= res_nxt[0];
    res_r[1] <= res_nxt[1];
    res_r[2] <= res_nxt[2];
    per_r    <= per_nxt;
  end

  // fade: reduce mod 1530, then split into thirds
  always_comb begin
    fade_s  = (step_r >= FADE_PERIOD) ? step_r - FADE_PERIOD : step_r;
    fade_d1 = fade_s - THIRD_LEN;
    fade_d2 = fade_s - THIRD_LEN_X2;
    if (fade_s < THIRD_LEN) begin
      fade_m   = 3'b001;
      fade_pos = fade_s[PosW-1:0];
    end else if (fade_s < THIRD_LEN_X2) begin
      fade_m   = 3'b010;
      fade_pos = fade_d1[PosW-1:0];
    end else begin
      fade_m   = 3'b100;
      fade_pos = fade_d2[PosW-1:0];
    end
  end

  // monofade: reduce mod 510, pick largest channel, later wins ties
  always_comb begin
    if (step_r >= MONO_X4) begin
      mono_s = step_r - MONO_X4;
    end else if (step_r >= MONO_X3) begin
      mono_s = step_r - MONO_X3;
    end else if (step_r >= MONO_X2) begin
      mono_s = step_r - MONO_X2;
    end else if (step_r >= MONO_PERIOD) begin
      mono_s = step_r - MONO_PERIOD;
    end else begin
      mono_s = step_r;
    end
    gb_max = (base_r[1] > base_r[2]) ? base_r[1] : base_r[2];
    if (base_r[0] > gb_max) begin
      mono_m = 3'b001;
    end else if (base_r[1] > base_r[2]) begin
      mono_m = 3'b010;
    end else begin
      mono_m = 3'b100;
    end
  end

  always_comb begin
    unique case (imode_r)
      MODE_FADE: begin
        ramp_m  = fade_m;
        pos     = fade_pos;
        per_nxt = FADE_PERIOD;
      end
      MODE_BIFADE: begin
        ramp_m  = fade_m | {fade_m[1:0], fade_m[2]};
        pos     = fade_pos;
        per_nxt = FADE_PERIOD;
      end
      MODE_MONO: begin
        ramp_m  = mono_m;
        pos     = mono_s[PosW-1:0];
        per_nxt = MONO_PERIOD;
      end
      default: begin
        ramp_m  = 3'b000;
        pos     = fade_pos;
        per_nxt = STATIC_PER;
      end
    endcase
    tri_down = RAMP_LEN - pos;
    tri_lvl  = (pos < HALF_RAMP) ? pos[ColW-1:0] : tri_down[ColW-1:0];
  end

  for (genvar c = 0; c < 3; c++) begin : g_chan
    lcfs_ramp u_ramp (
      .base  (base_r[c]),
      .lvl   (tri_lvl),
      .level (ramped[c])
    );

    always_comb begin
      if (imode_r == MODE_STATIC) begin
        res_nxt[c] = base_r[c];
      end else if (ramp_m[c]) begin
        res_nxt[c] = ramped[c];
      end else begin
        res_nxt[c] = '0;
      end
    end
  end

  assign out_valid     = res_vld_r;
  assign out_red_out   = res_r[0];
  assign out_green_out = res_r[1];
  assign out_blue_out  = res_r[2];
  assign out_period    = per_r;

endmodule

`default_nettype wire

// File: hw/rtl/lcfs_checker.sv
// ----------------------------------------------------------------------------
// lcfs_checker
// Port-level checks on the shader core, bound into the shader core module.
// ----------------------------------------------------------------------------
`default_nettype none

module lcfs_checker
  import lcfs_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             start,
  input wire logic             busy,
  input wire logic [ColW-1:0]  in_red_in,
  input wire logic [ColW-1:0]  in_green_in,
  input wire logic [ColW-1:0]  in_blue_in,
  input wire logic             out_valid,
  input wire logic [ColW-1:0]  out_red_out,
  input wire logic [ColW-1:0]  out_green_out,
  input wire logic [ColW-1:0]  out_blue_out,
  input wire logic [StepW-1:0] out_period
);

  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("transfer produced no result");

  a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without a transfer");

  a_period: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_period == STATIC_PER || out_period == MONO_PERIOD ||
                   out_period == FADE_PERIOD))
    else $error("bad period");

  a_static: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_period == STATIC_PER) |->
      (out_red_out == $past(in_red_in, 2) && out_green_out == $past(in_green_in, 2) &&
       out_blue_out == $past(in_blue_in, 2)))
    else $error("static colour altered");

  a_mono: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_period == MONO_PERIOD) |->
      ($countones({out_red_out != '0, out_green_out != '0, out_blue_out != '0}) <= 1))
    else $error("monofade lit more than one channel");

endmodule

bind led_color_fade_shader_core lcfs_checker u_lcfs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_red_in     (in_red_in),
  .in_green_in   (in_green_in),
  .in_blue_in    (in_blue_in),
  .out_valid     (out_valid),
  .out_red_out   (out_red_out),
  .out_green_out (out_green_out),
  .out_blue_out  (out_blue_out),
  .out_period    (out_period)
);

`default_nettype wire

// File: verif/lcfs_checker.sv
// ----------------------------------------------------------------------------
// tb_lcfs_checker
// Monitors the shader's input, result and configuration channels. Each input
// transfer is run through a local model of the shading maths and queued; each
// result strobe is compared field by field with the oldest queued pixel.
// ----------------------------------------------------------------------------
module tb_lcfs_checker
  import lcfs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  logic [ColW-1:0]  in_red_in,
  input  logic [ColW-1:0]  in_green_in,
  input  logic [ColW-1:0]  in_blue_in,
  input  logic [StepW-1:0] in_step,
  input  logic             out_valid,
  input  logic [ColW-1:0]  out_red_out,
  input  logic [ColW-1:0]  out_green_out,
  input  logic [ColW-1:0]  out_blue_out,
  input  logic [StepW-1:0] out_period,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [1:0]       cfg_data,
  input  logic             end_of_test,
  output int               error_count,
  output int               pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ColW-1:0]  red;
    logic [ColW-1:0]  green;
    logic [ColW-1:0]  blue;
    logic [StepW-1:0] period;
  } shaded_pixel_t;

  shade_mode_t   cur_mode;
  shaded_pixel_t expected_pixels[$];
  bit            leftovers_checked;

  function automatic int unsigned ramp_level(int unsigned base, int unsigned pos);
    if (pos < int'(HALF_RAMP))
      return (pos * base) / int'(HALF_RAMP);
    return (base * (int'(RAMP_LEN) - pos)) / int'(HALF_RAMP);
  endfunction

  function automatic shaded_pixel_t shade_pixel(shade_mode_t mode,
                                                logic [ColW-1:0] r,
                                                logic [ColW-1:0] g,
                                                logic [ColW-1:0] b,
                                                logic [StepW-1:0] stp);
    int unsigned   base[3];
    int unsigned   lvl[3];
    int unsigned   s;
    int unsigned   ch;
    int unsigned   pos;
    int unsigned   nx;
    int unsigned   gb;
    shaded_pixel_t res;
    base[0] = r;
    base[1] = g;
    base[2] = b;
    lvl[0] = 0;
    lvl[1] = 0;
    lvl[2] = 0;
    case (mode)
      MODE_STATIC: begin
        lvl = base;
        res.period = STATIC_PER;
      end
      MODE_FADE, MODE_BIFADE: begin
        s   = int'(stp) % int'(FADE_PERIOD);
        ch  = s / int'(THIRD_LEN);
        pos = s % int'(THIRD_LEN);
        if (ch > 2) ch = 2;
        lvl[ch] = ramp_level(base[ch], pos);
        if (mode == MODE_BIFADE) begin
          nx = (ch == 2) ? 0 : ch + 1;
          lvl[nx] = ramp_level(base[nx], pos);
        end
        res.period = FADE_PERIOD;
      end
      default: begin
        s  = int'(stp) % int'(MONO_PERIOD);
        gb = (base[1] > base[2]) ? base[1] : base[2];
        // ties go to the later channel
        if (base[0] > gb) ch = 0;
        else if (base[1] > base[2]) ch = 1;
        else ch = 2;
        lvl[ch] = ramp_level(base[ch], s);
        res.period = MONO_PERIOD;
      end
    endcase
    res.red   = lvl[0][ColW-1:0];
    res.green = lvl[1][ColW-1:0];
    res.blue  = lvl[2][ColW-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    shaded_pixel_t exp_px;
    logic [StepW-1:0] exp_f[4];
    logic [StepW-1:0] act_f[4];
    string fname[4];
    int errs;
    fname = '{"red_out", "green_out", "blue_out", "period"};
    errs = 0;
    if (!rst_n) begin
      cur_mode = MODE_STATIC;
      expected_pixels.delete();
      error_count <= 0;
      leftovers_checked <= 1'b0;
    end else begin
      if (out_valid) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected result r=%0d g=%0d b=%0d period=%0d", $time,
                   out_red_out, out_green_out, out_blue_out, out_period);
          errs++;
        end else begin
          exp_px = expected_pixels.pop_front();
          exp_f = '{StepW'(exp_px.red), StepW'(exp_px.green), StepW'(exp_px.blue),
                    exp_px.period};
          act_f = '{StepW'(out_red_out), StepW'(out_green_out), StepW'(out_blue_out),
                    out_period};
          for (int i = 0; i < 4; i++) begin
            if (exp_f[i] !== act_f[i]) begin
              $display("%0t: %s mismatch, expected %0d actual %0d", $time,
                       fname[i], exp_f[i], act_f[i]);
              errs++;
            end
          end
        end
      end
      if (start && !busy)
        expected_pixels.push_back(shade_pixel(cur_mode, in_red_in, in_green_in,
                                              in_blue_in, in_step));
      if (cfg_valid && cfg_ready)
        cur_mode = shade_mode_t'(cfg_data);
      if (end_of_test && !leftovers_checked) begin
        leftovers_checked <= 1'b1;
        if (expected_pixels.size() != 0) begin
          $display("%0t: %0d expected results never arrived", $time,
                   expected_pixels.size());
          errs += expected_pixels.size();
        end
      end
      error_count <= error_count + errs;
    end
    pending_count <= expected_pixels.size();
  end

endmodule

// File: verif/tb_led_color_fade_shader_core.sv
// ----------------------------------------------------------------------------
// tb_led_color_fade_shader_core
// Drives pixels through the colour fade shader in every shade mode: a short
// directed set of boundary steps and channel ties, then random pixels with
// random gaps and drain pauses. The checker module does the scoring.
// ----------------------------------------------------------------------------
module tb_led_color_fade_shader_core
  import lcfs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit  = 200000;
  localparam int NumPhases   = 10;
  localparam int PhaseItems  = 160;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [ColW-1:0]  in_red_in;
  logic [ColW-1:0]  in_green_in;
  logic [ColW-1:0]  in_blue_in;
  logic [StepW-1:0] in_step;
  logic             out_valid;
  logic [ColW-1:0]  out_red_out;
  logic [ColW-1:0]  out_green_out;
  logic [ColW-1:0]  out_blue_out;
  logic [StepW-1:0] out_period;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [1:0]       cfg_data;
  logic             end_of_test;
  int               error_count;
  int               pending_count;
  int               cycle_count;
  int               idle_pct;

  shade_mode_t phase_modes[NumPhases] = '{MODE_STATIC, MODE_FADE, MODE_BIFADE, MODE_MONO,
                                          MODE_MONO, MODE_FADE, MODE_STATIC, MODE_BIFADE,
                                          MODE_FADE, MODE_MONO};
  logic [StepW-1:0] edge_steps[20] = '{0, 254, 255, 256, 509, 510, 511, 764, 765, 1019,
                                       1020, 1021, 1274, 1275, 1529, 1530, 1531, 2039,
                                       2040, 2047};

  led_color_fade_shader_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_red_in(in_red_in), .in_green_in(in_green_in), .in_blue_in(in_blue_in),
    .in_step(in_step),
    .out_valid(out_valid), .out_red_out(out_red_out), .out_green_out(out_green_out),
    .out_blue_out(out_blue_out), .out_period(out_period),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  tb_lcfs_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_red_in(in_red_in), .in_green_in(in_green_in), .in_blue_in(in_blue_in),
    .in_step(in_step),
    .out_valid(out_valid), .out_red_out(out_red_out), .out_green_out(out_green_out),
    .out_blue_out(out_blue_out), .out_period(out_period),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .end_of_test(end_of_test), .error_count(error_count), .pending_count(pending_count)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_led_color_fade_shader_core: errors");
    $finish;
  end

  task automatic send_pixel(input logic [ColW-1:0] r, input logic [ColW-1:0] g,
                            input logic [ColW-1:0] b, input logic [StepW-1:0] s);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start       <= 1'b0;
      in_red_in   <= ColW'($urandom);
      in_green_in <= ColW'($urandom);
      in_blue_in  <= ColW'($urandom);
      in_step     <= StepW'($urandom);
      @(posedge clk);
    end
    @(negedge clk);
    start       <= 1'b1;
    in_red_in   <= r;
    in_green_in <= g;
    in_blue_in  <= b;
    in_step     <= s;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic write_mode(input shade_mode_t m);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [ColW-1:0] rand_level();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return ColW'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [StepW-1:0] rand_step();
    case ($urandom_range(7))
      0, 1:    return edge_steps[$urandom_range(19)];
      2:       return StepW'($urandom_range(int'(MONO_PERIOD) - 1));
      default: return StepW'($urandom_range(2047));
    endcase
  endfunction

  task automatic run_directed(input shade_mode_t m);
    case (m)
      MODE_STATIC: begin
        send_pixel(255, 0, 255, 2047);
        send_pixel(0, 255, 0, 0);
      end
      MODE_FADE: begin
        send_pixel(255, 255, 255, 0);
        send_pixel(255, 255, 255, 254);
        send_pixel(255, 255, 255, 255);
        send_pixel(255, 255, 255, 509);
        send_pixel(200, 100, 50, 510);
        send_pixel(1, 2, 3, 1020);
        send_pixel(255, 255, 255, 1529);
        send_pixel(255, 255, 255, 2047);
      end
      MODE_BIFADE: begin
        send_pixel(255, 128, 7, 1529);
        send_pixel(255, 255, 255, 1530);
        send_pixel(10, 255, 255, 1019);
        send_pixel(255, 255, 255, 765);
        send_pixel(0, 0, 0, 2047);
      end
      default: begin
        // channel ties: later channel takes the ramp
        send_pixel(9, 9, 9, 255);
        send_pixel(200, 200, 10, 255);
        send_pixel(200, 10, 10, 100);
        send_pixel(10, 200, 200, 300);
        send_pixel(255, 255, 255, 509);
        send_pixel(0, 0, 0, 0);
        send_pixel(255, 0, 0, 510);
        send_pixel(0, 255, 0, 2047);
      end
    endcase
  endtask

  initial begin
    logic [ColW-1:0] r;
    logic [ColW-1:0] g;
    logic [ColW-1:0] b;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_red_in   = '0;
    in_green_in = '0;
    in_blue_in  = '0;
    in_step     = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    end_of_test = 1'b0;
    idle_pct    = 9;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      write_mode(phase_modes[p]);
      // one long stretch without gaps
      idle_pct = (p == 5) ? 0 : 9;
      if (p < 4) run_directed(phase_modes[p]);
      for (int i = 0; i < PhaseItems; i++) begin
        if ((p == 1 && i == PhaseItems / 2) || $urandom_range(199) == 0)
          wait_drained();
        r = rand_level();
        g = rand_level();
        b = rand_level();
        case ($urandom_range(9))
          0: g = r;
          1: b = g;
          2: begin
            g = r;
            b = r;
          end
          default: ;
        endcase
        send_pixel(r, g, b, rand_step());
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    @(negedge clk);
    end_of_test <= 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    if (error_count == 0)
      $display("tb_led_color_fade_shader_core: clean");
    else
      $display("tb_led_color_fade_shader_core: errors");
    $finish;
  end

endmodule
